### hw/rtl/ccpp_pkg.sv
// shared types, constants and elaboration-time tables for the color correction pipe
// depends on nothing; imported by ccpp_channel and color_correction_pixel_pipe
`default_nettype none

package ccpp_pkg;

   localparam int COEF_FRAC_BITS = 12;

   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int COEFS_W   = 3 * COEF_W;
   localparam int MUL_W     = COEF_W + PIX_W + 1;
   localparam int NUM_W     = MUL_W + 4;
   localparam int GAIN_W    = 20;
   localparam int BRIGHT_W  = 9;
   localparam int SCALED_W  = NUM_W + GAIN_W + 1;
   localparam int SHIFT     = COEF_FRAC_BITS + 17;
   localparam int K_W       = SCALED_W - SHIFT;
   localparam int LEVEL_W   = 8;
   localparam int LEVEL_COUNT = 201;
   localparam int INDEX_W   = 3;

   localparam logic [INDEX_W-1:0] REG_RED_COEFFS   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_GREEN_COEFFS = 3'd1;
   localparam logic [INDEX_W-1:0] REG_BLUE_COEFFS  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_BRIGHTNESS   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_CONTRAST     = 3'd4;
   localparam logic [INDEX_W-1:0] REG_INVERT       = 3'd5;

   localparam logic signed [K_W-1:0] K_LOW  = K_W'(-128);
   localparam logic signed [K_W-1:0] K_HIGH = K_W'(128);
   localparam logic signed [K_W-1:0] K_MID  = K_W'(127);

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   typedef logic [GAIN_W-1:0] gain_table_type [LEVEL_COUNT];
   typedef logic signed [BRIGHT_W-1:0] bright_table_type [LEVEL_COUNT];

   function automatic gain_table_type build_gain_table();
      gain_table_type t;
      longint n;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         n = longint'(i);
         if (i >= 100) begin
            t[i] = GAIN_W'((n * n * n * 65536 + 500000) / 1000000);
         end else begin
            t[i] = GAIN_W'((n * 65536 + 50) / 100);
         end
      end
      return t;
   endfunction

   function automatic bright_table_type build_bright_table();
      bright_table_type t;
      longint prod;
      longint q;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         prod = longint'(i - 100) * 128;
         q = prod / 100;
         if ((prod % 100) != 0 && prod < 0) begin
            q = q - 1;
         end
         t[i] = BRIGHT_W'(q);
      end
      return t;
   endfunction

   localparam gain_table_type   GAIN_TABLE   = build_gain_table();
   localparam bright_table_type BRIGHT_TABLE = build_bright_table();

   // saturate a raw level to -100..100 and offset it to a table index
   function automatic logic [LEVEL_W-1:0] level_index(input logic [LEVEL_W-1:0] raw);
      logic signed [LEVEL_W-1:0] lvl;
      logic signed [LEVEL_W:0]   wide;
      lvl = $signed(raw);
      wide = (LEVEL_W+1)'(lvl) + (LEVEL_W+1)'(100);
      if (lvl < -8'sd100) begin
         wide = '0;
      end else if (lvl > 8'sd100) begin
         wide = (LEVEL_W+1)'(200);
      end
      return wide[LEVEL_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ccpp_channel.sv
// datapath of one output channel: matrix row, brightness, contrast, clamp, invert
// depends on ccpp_pkg; stage enables come from the control in the top level
`default_nettype none

module ccpp_channel
   import ccpp_pkg::*;
(
   input  wire logic                       clock,
   input  wire stage_en_type               en,
   input  wire logic [COEFS_W-1:0]         coeffs,
   input  wire logic [PIX_W-1:0]           pix_red,
   input  wire logic [PIX_W-1:0]           pix_green,
   input  wire logic [PIX_W-1:0]           pix_blue,
   input  wire logic signed [BRIGHT_W-1:0] bright,
   input  wire logic [GAIN_W-1:0]          gain,
   input  wire logic                       invert,
   output logic [PIX_W-1:0]                result
);

   logic signed [MUL_W-1:0]    prod_in [3];
   logic signed [MUL_W-1:0]    prod_ff [3];
   logic signed [NUM_W-1:0]    num_in;
   logic signed [NUM_W-1:0]    num_ff;
   logic signed [SCALED_W-1:0] scaled_in;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic [PIX_W-1:0]           result_in;
   logic [PIX_W-1:0]           result_ff;
   logic signed [BRIGHT_W:0]   bias;
   logic signed [NUM_W-1:0]    acc;
   logic signed [K_W-1:0]      k;
   logic [PIX_W-1:0]           pix [3];

   assign pix[0] = pix_red;
   assign pix[1] = pix_green;
   assign pix[2] = pix_blue;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = MUL_W'($signed(coeffs[i*COEF_W +: COEF_W]))
                    * MUL_W'($signed({1'b0, pix[i]}));
      end
   end

   always_comb begin
      bias = $signed({bright, 1'b0}) - $signed((BRIGHT_W+1)'(255));
      acc = NUM_W'(prod_ff[0]) + NUM_W'(prod_ff[1]) + NUM_W'(prod_ff[2]);
      num_in = (acc <<< 1) + (NUM_W'(bias) <<< COEF_FRAC_BITS);
   end

   assign scaled_in = SCALED_W'(num_ff) * SCALED_W'($signed({1'b0, gain}));

   always_comb begin
      k = scaled_ff[SCALED_W-1:SHIFT];
      if (k <= K_LOW) begin
         result_in = invert ? '1 : '0;
      end else if (k >= K_HIGH) begin
         result_in = invert ? '0 : '1;
      end else if (invert) begin
         result_in = PIX_W'(K_MID - k);
      end else begin
         result_in = PIX_W'(k + K_MID);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
      if (en.s2) begin
         num_ff <= num_in;
      end
      if (en.s3) begin
         scaled_ff <= scaled_in;
      end
      if (en.s4) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### hw/rtl/color_correction_pixel_pipe.sv
// top level of the color correction pipe: control registers, stage control, three channels
// depends on ccpp_pkg and ccpp_channel
//
// usage
//   req_* carries one rgb pixel a request, rsp_* one corrected pixel, both valid/ready.
//   csr_* writes one control register: index 0..2 matrix rows, 3 brightness,
//   4 contrast, 5 invert; other indexes are ignored. csr_ready is always high.
//   write control registers only while no request is in flight.
//   rsp_valid rises once an accepted request has passed the four-stage pipe:
//   products, sum and bias, gain multiply, clamp and output register; one pixel
//   per cycle sustained while the receiver does not stall.
//   each stage holds its data while the next stage is full, so when the receiver
//   stalls the empty stages keep filling and req_ready drops only once all four
//   stages hold a pixel; nothing is lost or repeated.
//   synchronous reset empties the pipe and restores the identity matrix, zero
//   brightness and contrast, and no inversion.
`default_nettype none

module color_correction_pixel_pipe
   import ccpp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [PIX_W-1:0]    req_in_red,
   input  wire logic [PIX_W-1:0]    req_in_green,
   input  wire logic [PIX_W-1:0]    req_in_blue,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [PIX_W-1:0]         rsp_out_red,
   output logic [PIX_W-1:0]         rsp_out_green,
   output logic [PIX_W-1:0]         rsp_out_blue,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [INDEX_W-1:0]  csr_index,
   input  wire logic [COEFS_W-1:0]  csr_data
);

   logic [COEFS_W-1:0] red_coeffs_ff;
   logic [COEFS_W-1:0] green_coeffs_ff;
   logic [COEFS_W-1:0] blue_coeffs_ff;
   logic [LEVEL_W-1:0] bright_level_ff;
   logic [LEVEL_W-1:0] contrast_level_ff;
   logic               invert_ff;

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;
   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy4;

   stage_en_type               en;
   logic signed [BRIGHT_W-1:0] bright;
   logic [GAIN_W-1:0]          gain;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_coeffs_ff     <= COEFS_W'(1) << COEF_FRAC_BITS;
         green_coeffs_ff   <= COEFS_W'(1) << (COEF_FRAC_BITS + COEF_W);
         blue_coeffs_ff    <= COEFS_W'(1) << (COEF_FRAC_BITS + 2 * COEF_W);
         bright_level_ff   <= '0;
         contrast_level_ff <= '0;
         invert_ff         <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_RED_COEFFS:   red_coeffs_ff     <= csr_data;
            REG_GREEN_COEFFS: green_coeffs_ff   <= csr_data;
            REG_BLUE_COEFFS:  blue_coeffs_ff    <= csr_data;
            REG_BRIGHTNESS:   bright_level_ff   <= csr_data[LEVEL_W-1:0];
            REG_CONTRAST:     contrast_level_ff <= csr_data[LEVEL_W-1:0];
            REG_INVERT:       invert_ff         <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign bright = BRIGHT_TABLE[level_index(bright_level_ff)];
   assign gain   = GAIN_TABLE[level_index(contrast_level_ff)];

   assign rdy4 = !s4_valid_ff || rsp_ready;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign en.s1 = rdy1;
   assign en.s2 = rdy2;
   assign en.s3 = rdy3;
   assign en.s4 = rdy4;

   assign req_ready = rdy1;
   assign rsp_valid = s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy4) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   ccpp_channel u_red (
      .clock     (clock),
      .en        (en),
      .coeffs    (red_coeffs_ff),
      .pix_red   (req_in_red),
      .pix_green (req_in_green),
      .pix_blue  (req_in_blue),
      .bright    (bright),
      .gain      (gain),
      .invert    (invert_ff),
      .result    (rsp_out_red)
   );

   ccpp_channel u_green (
      .clock     (clock),
      .en        (en),
      .coeffs    (green_coeffs_ff),
      .pix_red   (req_in_red),
      .pix_green (req_in_green),
      .pix_blue  (req_in_blue),
      .bright    (bright),
      .gain      (gain),
      .invert    (invert_ff),
      .result    (rsp_out_green)
   );

   ccpp_channel u_blue (
      .clock     (clock),
      .en        (en),
      .coeffs    (blue_coeffs_ff),
      .pix_red   (req_in_red),
      .pix_green (req_in_green),
      .pix_blue  (req_in_blue),
      .bright    (bright),
      .gain      (gain),
      .invert    (invert_ff),
      .result    (rsp_out_blue)
   );

   // an accepted request always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request missing from first stage");

   // a pixel leaving the gain stage reaches the output register
   a_s3_to_out: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && rdy4) |=> rsp_valid)
      else $error("pixel lost between gain stage and output");

   // an empty pipe never refuses a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !s4_valid_ff) |-> req_ready)
      else $error("empty pipe not ready");

endmodule

`default_nettype wire
